// File: rtl/tsetlin_machine_train_infer_macros.svh
// assertion macros for the tsetlin machine block
// expects clk and arst_n in the scope of every use
`ifndef TSETLIN_MACHINE_TRAIN_INFER_MACROS_SVH
`define TSETLIN_MACHINE_TRAIN_INFER_MACROS_SVH
`ifndef SYNTHESIS
`define TMTI_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmti implication check failed");
`define TMTI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmti next-cycle check failed");
`else
`define TMTI_ASSERT_IMPLY(label, ante, cons)
`define TMTI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/tmti_pkg.sv
// shared types and constants of the tsetlin machine block
// no dependencies
`default_nettype none
package tmti_pkg;

	localparam int OP_W       = 2;
	localparam int WORD_W     = 32;
	localparam int SUM_W      = 12;
	localparam int COUNT_W    = 8;
	localparam int DRAW_W     = 24;
	localparam int PROB_W     = 25;
	localparam int DIV_DVD_W  = 36;
	localparam int DIV_DVS_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_SCORE  = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_W-1:0] OP_INIT   = 2'd2;
	localparam logic [OP_W-1:0] OP_REINIT = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VOTE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPECIFICITY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURES       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAUSES        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED           = 3'd4;

	localparam logic [63:0]          GOLDEN     = 64'h9E3779B97F4A7C15;
	localparam logic [PROB_W-1:0]    PROB_ONE   = 25'h1000000;
	localparam logic [DRAW_W-1:0]    PROB_HALF  = 24'h800000;

	// controller to datapath commands
	typedef struct packed {
		logic op_load;
		logic word_wr;
		logic wpos_clr;
		logic seed_load;
		logic draw;
		logic rand_wr;
		logic k_clr;
		logic k_inc;
		logic j_clr;
		logic j_inc;
		logic sum_clr;
		logic rd_en;
		logic eval_step;
		logic div_start;
		logic div_sel;
		logic th_load;
		logic p1_load;
		logic fb_mode_load;
		logic fb_a;
		logic fb_b;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic            k_last;
		logic            j_last;
		logic            clause_end;
		logic            div_busy;
		logic            cd_type1;
		logic            cd_type2;
		logic            out_free;
		logic [OP_W-1:0] op;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/tmti_ifs.sv
// valid/ready channel interfaces for samples and results
// depends on tmti_pkg
`default_nettype none
interface tmti_sample_if;
	import tmti_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [WORD_W-1:0] feature_word;
	logic              last_word;
	logic              target;
	modport source(output valid, output operation, output feature_word, output last_word,
		output target, input ready);
	modport sink(input valid, input operation, input feature_word, input last_word,
		input target, output ready);
endinterface

interface tmti_result_if;
	import tmti_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] vote_total;
	logic [OP_W-1:0]         done_operation;
	modport source(output valid, output vote_total, output done_operation, input ready);
	modport sink(input valid, input vote_total, input done_operation, output ready);
endinterface
`default_nettype wire

// File: rtl/tmti_divider.sv
// serial restoring divider, one quotient bit per cycle
// depends on tmti_pkg
`default_nettype none
module tmti_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tmti_pkg::DIV_DVD_W-1:0] dividend,
	input  logic [tmti_pkg::DIV_DVS_W-1:0] divisor,
	output logic                           busy,
	output logic [tmti_pkg::DIV_DVD_W-1:0] quotient
);
	import tmti_pkg::*;

	localparam int CNT_W = $clog2(DIV_DVD_W + 1);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_DVS_W:0]   rem_sh;
	logic [DIV_DVS_W:0]   rem_sub;
	logic                 q_bit;

	// trial subtract
	always_comb begin
		rem_sh  = {rem_q, dvd_q[DIV_DVD_W-1]};
		q_bit   = rem_sh >= {1'b0, dvs_q};
		rem_sub = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift registers, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], q_bit};
			rem_q <= rem_sub[DIV_DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

// File: rtl/tmti_rng.sv
// xorshift128+ generator giving one 24-bit draw per step
// depends on tmti_pkg
`default_nettype none
module tmti_rng (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seed_load,
	input  logic [31:0]                 seed,
	input  logic                        step,
	output logic [tmti_pkg::DRAW_W-1:0] draw
);
	import tmti_pkg::*;

	logic [63:0] s0_q;
	logic [63:0] s1_q;
	logic [63:0] a_mix;
	logic [63:0] s1_next;
	logic [63:0] sum_w;
	logic [31:0] seed_inc;

	// next state and the draw it yields
	always_comb begin
		a_mix    = s0_q ^ (s0_q << 23);
		s1_next  = a_mix ^ s1_q ^ (a_mix >> 18) ^ (s1_q >> 5);
		sum_w    = s1_next + s1_q;
		seed_inc = seed + 32'd1;
	end

	assign draw = sum_w[63:40];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q <= '0;
			s1_q <= '0;
		end else if (seed_load) begin
			s0_q <= {32'd0, seed} ^ GOLDEN;
			s1_q <= {32'd0, seed_inc} ^ GOLDEN;
		end else if (step) begin
			s0_q <= s1_q;
			s1_q <= s1_next;
		end
	end
endmodule
`default_nettype wire

// File: rtl/tmti_datapath.sv
// datapath: registers, automaton memory, feature buffer, counters, feedback
// depends on tmti_pkg, tmti_rng and tmti_divider
`default_nettype none
module tmti_datapath #(
	parameter int MAX_FEATURE_COUNT = 256,
	parameter int MAX_CLAUSE_COUNT  = 64,
	parameter int STATE_COUNT       = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tmti_pkg::cmd_t                  cmd,
	output tmti_pkg::sts_t                  sts,
	input  logic                            cfg_we,
	input  logic [tmti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmti_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tmti_pkg::OP_W-1:0]       operation,
	input  logic [tmti_pkg::WORD_W-1:0]     feature_word,
	input  logic                            target,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic signed [tmti_pkg::SUM_W-1:0] vote_total,
	output logic [tmti_pkg::OP_W-1:0]       done_operation
);
	import tmti_pkg::*;

	localparam int FW        = (MAX_FEATURE_COUNT > 1) ? $clog2(MAX_FEATURE_COUNT) : 1;
	localparam int CW        = (MAX_CLAUSE_COUNT > 1) ? $clog2(MAX_CLAUSE_COUNT) : 1;
	localparam int SLOTS     = (MAX_FEATURE_COUNT + 31) / 32;
	localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AW        = CW + FW;
	localparam int MEM_DEPTH = 1 << AW;
	localparam logic [COUNT_W-1:0] ST_LO  = COUNT_W'(STATE_COUNT);
	localparam logic [COUNT_W-1:0] ST_HI  = COUNT_W'(STATE_COUNT + 1);
	localparam logic [COUNT_W-1:0] ST_MAX = COUNT_W'(2 * STATE_COUNT);
	localparam logic [COUNT_W-1:0] ONE_C  = COUNT_W'(1);

	// configuration registers
	logic [10:0] vt_q;
	logic [15:0] spec_q;
	logic [8:0]  fiu_q;
	logic [6:0]  ciu_q;
	logic [31:0] seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vt_q   <= 11'd15;
			spec_q <= 16'd4;
			fiu_q  <= 9'd256;
			ciu_q  <= 7'd64;
			seed_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VOTE_THRESHOLD: vt_q   <= cfg_data[10:0];
				CFG_SPECIFICITY:    spec_q <= cfg_data[15:0];
				CFG_FEATURES:       fiu_q  <= cfg_data[8:0];
				CFG_CLAUSES:        ciu_q  <= cfg_data[6:0];
				CFG_SEED:           seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped sizes and threshold
	logic [12:0] nf;
	logic [10:0] nc;
	logic [10:0] tc;

	always_comb begin
		if (fiu_q == '0)
			nf = 13'd1;
		else if (13'(fiu_q) > 13'(MAX_FEATURE_COUNT))
			nf = 13'(MAX_FEATURE_COUNT);
		else
			nf = 13'(fiu_q);
		if (ciu_q == '0)
			nc = 11'd1;
		else if (11'(ciu_q) > 11'(MAX_CLAUSE_COUNT))
			nc = 11'(MAX_CLAUSE_COUNT);
		else
			nc = 11'(ciu_q);
		if (vt_q == '0)
			tc = 11'd1;
		else if (vt_q > 11'd1024)
			tc = 11'd1024;
		else
			tc = vt_q;
	end

	// clause and literal counters, word position
	logic [FW-1:0] k_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] j_next;
	logic [SW-1:0] wpos_q;
	logic [OP_W-1:0] op_q;
	logic          target_q;
	logic          k_last;
	logic          j_last;

	assign k_last = (k_q == FW'(nf - 13'd1));
	assign j_last = (j_q == CW'(nc - 11'd1));
	assign j_next = cmd.j_clr ? '0 : (cmd.j_inc ? j_q + 1'b1 : j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			j_q    <= '0;
			wpos_q <= '0;
			op_q   <= OP_SCORE;
		end else begin
			if (cmd.k_clr)
				k_q <= '0;
			else if (cmd.k_inc)
				k_q <= k_q + 1'b1;
			if (cmd.j_clr)
				j_q <= '0;
			else if (cmd.j_inc)
				j_q <= j_q + 1'b1;
			if (cmd.wpos_clr)
				wpos_q <= '0;
			else if (cmd.word_wr)
				wpos_q <= (wpos_q == SW'(SLOTS - 1)) ? '0 : wpos_q + 1'b1;
			if (cmd.op_load)
				op_q <= operation;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_load)
			target_q <= target;
	end

	// feature buffer
	logic [WORD_W-1:0] feat_q [0:SLOTS-1];
	logic              x_bit;

	always_ff @(posedge clk) begin
		if (cmd.word_wr)
			feat_q[wpos_q] <= feature_word;
	end

	assign x_bit = feat_q[SW'(k_q >> 5)][5'(k_q)];

	// generator
	logic [DRAW_W-1:0] draw;
	logic              rng_step;

	tmti_rng u_rng (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_load (cmd.seed_load),
		.seed      (seed_q),
		.step      (rng_step),
		.draw      (draw)
	);

	// automaton memory, one word holds both automata of a literal
	logic [2*COUNT_W-1:0] mem [0:MEM_DEPTH-1];
	logic [2*COUNT_W-1:0] rd_q;
	logic [2*COUNT_W-1:0] wdata;
	logic [AW-1:0]        addr;
	logic                 mem_we;
	logic [COUNT_W-1:0]   ta0;
	logic [COUNT_W-1:0]   ta1;

	assign addr = {j_q, k_q};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr] <= wdata;
		if (cmd.rd_en)
			rd_q <= mem[addr];
	end

	assign ta0 = rd_q[COUNT_W-1:0];
	assign ta1 = rd_q[2*COUNT_W-1:COUNT_W];

	// clause evaluation
	logic                    any_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    clause_res_q [0:MAX_CLAUSE_COUNT-1];
	logic                    cres_q;
	logic                    inc_lit;
	logic                    neg_lit;
	logic                    fail;
	logic                    any_now;
	logic                    clause_end;
	logic                    ok;
	logic                    cres;

	always_comb begin
		inc_lit    = ta0 > ST_LO;
		neg_lit    = ta1 > ST_LO;
		fail       = (inc_lit & ~x_bit) | (neg_lit & x_bit);
		any_now    = any_q | inc_lit | neg_lit;
		clause_end = fail | k_last;
		ok         = ~fail & (any_now | (op_q != OP_SCORE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
			sum_q <= '0;
		end else if (cmd.sum_clr) begin
			any_q <= 1'b0;
			sum_q <= '0;
		end else if (cmd.eval_step) begin
			if (clause_end) begin
				any_q <= 1'b0;
				if (ok)
					sum_q <= j_q[0] ? sum_q - 12'sd1 : sum_q + 12'sd1;
			end else begin
				any_q <= any_now;
			end
		end
	end

	// clause results, read one entry ahead so the data follows the clause counter
	always_ff @(posedge clk) begin
		if (cmd.eval_step && clause_end)
			clause_res_q[j_q] <= ok;
		cres_q <= clause_res_q[j_next];
	end

	assign cres = cres_q;

	// vote clipping and feedback chance operands
	logic signed [SUM_W-1:0] tpos;
	logic signed [SUM_W-1:0] sumc;
	logic signed [12:0]      numer;
	logic signed [12:0]      denom;
	logic                    th_zero;
	logic                    th_full;

	always_comb begin
		tpos = signed'({1'b0, tc});
		if (sum_q > tpos)
			sumc = tpos;
		else if (sum_q < -tpos)
			sumc = -tpos;
		else
			sumc = sum_q;
		numer   = target_q ? (13'(tpos) - 13'(sumc)) : (13'(tpos) + 13'(sumc));
		denom   = signed'({13'(tpos)} <<< 1);
		th_zero = numer <= 13'sd0;
		th_full = numer >= denom;
	end

	// shared divider for feedback chance and specificity
	logic [DIV_DVD_W-1:0] div_dvd;
	logic [DIV_DVS_W-1:0] div_dvs;
	logic [DIV_DVD_W-1:0] div_quo;
	logic                 div_busy;
	logic [PROB_W-1:0]    th_q;
	logic [PROB_W-1:0]    p1_q;
	logic [PROB_W-1:0]    p2;

	assign div_dvd = cmd.div_sel ? DIV_DVD_W'(PROB_ONE) : {numer[11:0], 24'd0};
	assign div_dvs = cmd.div_sel ? spec_q : {4'd0, denom[11:0]};

	tmti_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.th_load)
			th_q <= th_zero ? '0 : (th_full ? PROB_ONE : div_quo[PROB_W-1:0]);
		if (cmd.p1_load)
			p1_q <= (spec_q == '0) ? PROB_ONE : div_quo[PROB_W-1:0];
	end

	assign p2 = PROB_ONE - p1_q;

	// clause feedback selection
	logic pass;
	logic sign_match;

	assign pass       = {1'b0, draw} <= th_q;
	assign sign_match = j_q[0] != target_q;

	// literal feedback, step a on read data, step b on the work register
	logic               fb_t1_q;
	logic [COUNT_W-1:0] w0_q;
	logic [COUNT_W-1:0] w1_q;
	logic               up;
	logic [COUNT_W-1:0] tu;
	logic               cond_a;
	logic               hit_a;
	logic               bump_a;
	logic [COUNT_W-1:0] a_w0;
	logic [COUNT_W-1:0] a_w1;
	logic               bsel;
	logic [COUNT_W-1:0] tb;
	logic               cond_b;
	logic               dec_b;
	logic [COUNT_W-1:0] b_w0;
	logic [COUNT_W-1:0] b_w1;

	always_comb begin
		up     = ~x_bit;
		tu     = up ? ta1 : ta0;
		cond_a = fb_t1_q & (cres ? (tu < ST_MAX) : (ta0 > ONE_C));
		hit_a  = cres ? ({1'b0, draw} <= p2) : ({1'b0, draw} <= p1_q);
		bump_a = cond_a & hit_a;
		a_w0   = ta0;
		a_w1   = ta1;
		if (fb_t1_q) begin
			if (!cres)
				a_w0 = ta0 - COUNT_W'(bump_a);
			else if (up)
				a_w1 = ta1 + COUNT_W'(bump_a);
			else
				a_w0 = ta0 + COUNT_W'(bump_a);
		end else begin
			a_w0 = ta0 + COUNT_W'((ta0 <= ST_LO) & ~x_bit);
			a_w1 = ta1 + COUNT_W'((ta1 <= ST_LO) & x_bit);
		end
		bsel   = cres ? x_bit : 1'b1;
		tb     = bsel ? w1_q : w0_q;
		cond_b = fb_t1_q & (tb > ONE_C);
		dec_b  = cond_b & ({1'b0, draw} <= p1_q);
		b_w0   = w0_q - COUNT_W'(dec_b & ~bsel);
		b_w1   = w1_q - COUNT_W'(dec_b & bsel);
	end

	always_ff @(posedge clk) begin
		if (cmd.fb_mode_load)
			fb_t1_q <= pass & sign_match;
		if (cmd.fb_a) begin
			w0_q <= a_w0;
			w1_q <= a_w1;
		end
	end

	assign rng_step = cmd.draw | (cmd.fb_a & cond_a) | (cmd.fb_b & cond_b);
	assign mem_we   = cmd.rand_wr | cmd.fb_b;

	always_comb begin
		if (cmd.rand_wr)
			wdata = (draw <= PROB_HALF) ? {ST_HI, ST_LO} : {ST_LO, ST_HI};
		else
			wdata = {b_w1, b_w0};
	end

	// result register
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] vote_total_q;
	logic [OP_W-1:0]         done_op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			vote_total_q <= op_q[1] ? '0 : sumc;
			done_op_q    <= op_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign vote_total     = vote_total_q;
	assign done_operation = done_op_q;

	// status back to the controller
	always_comb begin
		sts.k_last     = k_last;
		sts.j_last     = j_last;
		sts.clause_end = clause_end;
		sts.div_busy   = div_busy;
		sts.cd_type1   = pass & sign_match;
		sts.cd_type2   = pass & ~sign_match & cres;
		sts.out_free   = ~out_valid_q | out_ready;
		sts.op         = op_q;
	end
endmodule
`default_nettype wire

// File: rtl/tmti_ctrl.sv
// controller state machine sequencing init, scoring and feedback
// depends on tmti_pkg
`default_nettype none
module tmti_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [tmti_pkg::OP_W-1:0] in_operation,
	input  logic                      in_last_word,
	output logic                      in_ready,
	input  tmti_pkg::sts_t            sts,
	output tmti_pkg::cmd_t            cmd
);
	import tmti_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_SEED    = 16'h0002,
		S_SKIP0   = 16'h0004,
		S_SKIP1   = 16'h0008,
		S_RAND    = 16'h0010,
		S_EREAD   = 16'h0020,
		S_EVAL    = 16'h0040,
		S_TH_GO   = 16'h0080,
		S_TH_WAIT = 16'h0100,
		S_P1_GO   = 16'h0200,
		S_P1_WAIT = 16'h0400,
		S_CDRAW   = 16'h0800,
		S_FREAD   = 16'h1000,
		S_FA      = 16'h2000,
		S_FB      = 16'h4000,
		S_DONE    = 16'h8000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op_load = 1'b1;
					if (in_operation == OP_INIT || in_operation == OP_REINIT) begin
						cmd.wpos_clr = 1'b1;
						cmd.j_clr    = 1'b1;
						cmd.k_clr    = 1'b1;
						state_d      = (in_operation == OP_INIT) ? S_SEED : S_RAND;
					end else begin
						cmd.word_wr = 1'b1;
						if (in_last_word) begin
							cmd.wpos_clr = 1'b1;
							cmd.sum_clr  = 1'b1;
							cmd.j_clr    = 1'b1;
							cmd.k_clr    = 1'b1;
							state_d      = S_EREAD;
						end
					end
				end
			end
			S_SEED: begin
				cmd.seed_load = 1'b1;
				state_d       = S_SKIP0;
			end
			S_SKIP0: begin
				cmd.draw = 1'b1;
				state_d  = S_SKIP1;
			end
			S_SKIP1: begin
				cmd.draw = 1'b1;
				state_d  = S_RAND;
			end
			// one literal pair randomized per cycle
			S_RAND: begin
				cmd.draw    = 1'b1;
				cmd.rand_wr = 1'b1;
				if (sts.k_last) begin
					cmd.k_clr = 1'b1;
					if (sts.j_last)
						state_d = S_DONE;
					else
						cmd.j_inc = 1'b1;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			S_EREAD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval_step = 1'b1;
				state_d       = S_EREAD;
				if (sts.clause_end) begin
					cmd.k_clr = 1'b1;
					if (sts.j_last)
						state_d = (sts.op == OP_SCORE) ? S_DONE : S_TH_GO;
					else
						cmd.j_inc = 1'b1;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			S_TH_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_TH_WAIT;
			end
			S_TH_WAIT: begin
				if (!sts.div_busy) begin
					cmd.th_load = 1'b1;
					state_d     = S_P1_GO;
				end
			end
			S_P1_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = S_P1_WAIT;
			end
			S_P1_WAIT: begin
				cmd.div_sel = 1'b1;
				if (!sts.div_busy) begin
					cmd.p1_load = 1'b1;
					cmd.j_clr   = 1'b1;
					cmd.k_clr   = 1'b1;
					state_d     = S_CDRAW;
				end
			end
			// per clause feedback draw
			S_CDRAW: begin
				cmd.draw = 1'b1;
				if (sts.cd_type1 || sts.cd_type2) begin
					cmd.fb_mode_load = 1'b1;
					cmd.k_clr        = 1'b1;
					state_d          = S_FREAD;
				end else if (sts.j_last) begin
					state_d = S_DONE;
				end else begin
					cmd.j_inc = 1'b1;
				end
			end
			S_FREAD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_FA;
			end
			S_FA: begin
				cmd.fb_a = 1'b1;
				state_d  = S_FB;
			end
			S_FB: begin
				cmd.fb_b = 1'b1;
				if (sts.k_last) begin
					cmd.k_clr = 1'b1;
					if (sts.j_last) begin
						state_d = S_DONE;
					end else begin
						cmd.j_inc = 1'b1;
						state_d   = S_CDRAW;
					end
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_FREAD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule
`default_nettype wire

// File: rtl/tsetlin_machine_train_infer.sv
// two-class tsetlin machine; a non-final word is only stored, init seeds and drops two
// draws, then init and reinit randomize every literal of every clause, score reads and
// evaluates the literals of each clause over the automaton memory port, update adds
// two divisions, a draw per clause and a read, step a and step b per literal of each
// clause that gets feedback; one item at a time, the input stalls while an item runs
// reset clears control, counters and generator; automata are undefined until (re)init
`default_nettype none
`include "tsetlin_machine_train_infer_macros.svh"
module tsetlin_machine_train_infer #(
	parameter int MAX_FEATURE_COUNT = 256,
	parameter int MAX_CLAUSE_COUNT  = 64,
	parameter int STATE_COUNT       = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tmti_sample_if.sink                     sample,
	tmti_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [tmti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmti_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tmti_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// sequencer
	tmti_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (sample.valid),
		.in_operation (sample.operation),
		.in_last_word (sample.last_word),
		.in_ready     (in_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	assign sample.ready = in_ready;

	// storage and arithmetic
	tmti_datapath #(
		.MAX_FEATURE_COUNT (MAX_FEATURE_COUNT),
		.MAX_CLAUSE_COUNT  (MAX_CLAUSE_COUNT),
		.STATE_COUNT       (STATE_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (sample.operation),
		.feature_word   (sample.feature_word),
		.target         (sample.target),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.vote_total     (result.vote_total),
		.done_operation (result.done_operation)
	);

	// checks
	`TMTI_ASSERT_NEXT(a_init_busy, sample.valid && sample.ready && sample.operation[1], !sample.ready)
	`TMTI_ASSERT_NEXT(a_word_idle, sample.valid && sample.ready && !sample.operation[1] && !sample.last_word, sample.ready)
	`TMTI_ASSERT_IMPLY(a_init_zero, result.valid && result.done_operation[1], result.vote_total == 12'sd0)
	`TMTI_ASSERT_IMPLY(a_sum_range, result.valid, (result.vote_total <= 12'sd1024) && (result.vote_total >= -12'sd1024))
endmodule
`default_nettype wire

// File: sim/tb_tsetlin_machine_train_infer.sv
// testbench for the two-class tsetlin machine: random and directed samples, scored
// against an in-bench predictor of votes, feedback and the xorshift128+ generator
// depends on tmti_pkg, tmti_ifs and tsetlin_machine_train_infer
`default_nettype none
module tb_tsetlin_machine_train_infer;
	import tmti_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NF_MAX = 256;
	localparam int NC_MAX = 64;
	localparam int STATES = 100;
	localparam longint ONE24 = 64'd1 << 24;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] word;
		logic              last;
		logic              tgt;
		bit                hold;
	} sample_t;

	typedef struct {
		logic signed [SUM_W-1:0] sum;
		logic [OP_W-1:0]         op;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tmti_sample_if smp();
	tmti_result_if res();

	tsetlin_machine_train_infer dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(smp.sink),
		.result(res.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	byte unsigned automata[0:NC_MAX*NF_MAX*2-1];
	logic [63:0] rng0, rng1;
	logic [31:0] words[0:7];
	int wpos;
	bit clause_hit[0:NC_MAX-1];
	int unsigned thr_reg, spec_reg, nfeat_reg, nclause_reg, seed_reg;

	sample_t pending_samples[$];
	outcome_t expected_outcomes[$];
	int errors;
	bit calm;
	int hold_seq;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.operation = OP_SCORE;
		smp.feature_word = '0;
		smp.last_word = 1'b0;
		smp.target = 1'b0;
		res.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_VOTE_THRESHOLD;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end

	task automatic report(string what, int got, int want);
		$display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int unsigned xs_draw();
		logic [63:0] a, b, s;
		a = rng0;
		b = rng1;
		rng0 = b;
		a = a ^ (a << 23);
		rng1 = a ^ b ^ (a >> 18) ^ (b >> 5);
		s = rng1 + b;
		return int'(s[63:40]);
	endfunction

	function automatic bit feat(int k);
		return words[(k >> 5) % 8][k & 31];
	endfunction

	function automatic void scramble();
		int nc, nf;
		nc = clampu(nclause_reg, 1, NC_MAX);
		nf = clampu(nfeat_reg, 1, NF_MAX);
		for (int j = 0; j < nc; j++)
			for (int k = 0; k < nf; k++) begin
				if (xs_draw() <= (ONE24 >> 1)) begin
					automata[(j*NF_MAX+k)*2] = STATES;
					automata[(j*NF_MAX+k)*2+1] = STATES + 1;
				end else begin
					automata[(j*NF_MAX+k)*2] = STATES + 1;
					automata[(j*NF_MAX+k)*2+1] = STATES;
				end
			end
	endfunction

	// clause vote sum, clipped; an empty clause counts only outside scoring
	function automatic int vote_sum(bit scoring);
		int nc, nf, t, sum, b;
		bit ok, any, inc, neg, x;
		nc = clampu(nclause_reg, 1, NC_MAX);
		nf = clampu(nfeat_reg, 1, NF_MAX);
		t = clampu(thr_reg, 1, 1024);
		sum = 0;
		for (int j = 0; j < nc; j++) begin
			ok = 1'b1;
			any = 1'b0;
			for (int k = 0; k < nf; k++) begin
				b = (j*NF_MAX+k)*2;
				inc = automata[b] > STATES;
				neg = automata[b+1] > STATES;
				x = feat(k);
				any = any | inc | neg;
				if ((inc && !x) || (neg && x)) begin
					ok = 1'b0;
					break;
				end
			end
			if (scoring && !any) ok = 1'b0;
			clause_hit[j] = ok;
			if (ok) sum += (j & 1) ? -1 : 1;
		end
		if (sum > t) sum = t;
		if (sum < -t) sum = -t;
		return sum;
	endfunction

	function automatic void feedback_one(int j);
		int nf, b, up;
		longint p1, p2;
		nf = clampu(nfeat_reg, 1, NF_MAX);
		p1 = spec_reg > 0 ? ONE24 / spec_reg : ONE24;
		p2 = ONE24 - p1;
		for (int k = 0; k < nf; k++) begin
			b = (j*NF_MAX+k)*2;
			if (!clause_hit[j]) begin
				if (automata[b] > 1 && xs_draw() <= p1) automata[b]--;
				if (automata[b+1] > 1 && xs_draw() <= p1) automata[b+1]--;
			end else begin
				up = feat(k) ? 0 : 1;
				if (automata[b+up] < 2*STATES && xs_draw() <= p2) automata[b+up]++;
				if (automata[b+1-up] > 1 && xs_draw() <= p1) automata[b+1-up]--;
			end
		end
	endfunction

	function automatic void feedback_two(int j);
		int nf, b;
		bit x;
		nf = clampu(nfeat_reg, 1, NF_MAX);
		for (int k = 0; k < nf; k++) begin
			b = (j*NF_MAX+k)*2;
			x = feat(k);
			if (automata[b] <= STATES && !x) automata[b]++;
			if (automata[b+1] <= STATES && x) automata[b+1]++;
		end
	endfunction

	function automatic int learn(bit tgt);
		int sum, t, y, numer, denom, nc, sign;
		longint th;
		sum = vote_sum(1'b0);
		t = clampu(thr_reg, 1, 1024);
		y = tgt ? 1 : -1;
		numer = t - y * sum;
		denom = 2 * t;
		nc = clampu(nclause_reg, 1, NC_MAX);
		if (numer <= 0) th = 0;
		else if (numer >= denom) th = ONE24;
		else th = (longint'(numer) * ONE24) / denom;
		for (int j = 0; j < nc; j++) begin
			sign = (j & 1) ? -1 : 1;
			if (xs_draw() <= th) begin
				if (sign == y) feedback_one(j);
				else if (clause_hit[j]) feedback_two(j);
			end
		end
		return sum;
	endfunction

	// advance the predictor by one accepted transfer
	function automatic void predict(sample_t it);
		outcome_t o;
		int sum;
		logic [31:0] s1;
		sum = 0;
		if (it.op == OP_INIT || it.op == OP_REINIT) begin
			if (it.op == OP_INIT) begin
				s1 = seed_reg + 1;
				rng0 = {32'd0, seed_reg} ^ GOLDEN;
				rng1 = {32'd0, s1} ^ GOLDEN;
				void'(xs_draw());
				void'(xs_draw());
			end
			scramble();
			wpos = 0;
		end else begin
			words[wpos] = it.word;
			wpos = (wpos + 1) % 8;
			if (!it.last) return;
			wpos = 0;
			sum = (it.op == OP_SCORE) ? vote_sum(1'b1) : learn(it.tgt);
		end
		o.sum = sum[SUM_W-1:0];
		o.op = it.op;
		expected_outcomes.push_back(o);
	endfunction

	// sample driver
	sample_t cur;
	int gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
			gap = 0;
		end else begin
			if (smp.valid && smp.ready) predict(cur);
			if (!(smp.valid && !smp.ready)) begin
				if (gap > 0) begin
					gap--;
					smp.valid <= 1'b0;
				end else if (pending_samples.size() > 0 &&
						!(pending_samples[0].hold && expected_outcomes.size() > 0)) begin
					cur = pending_samples.pop_front();
					smp.operation <= cur.op;
					smp.feature_word <= cur.word;
					smp.last_word <= cur.last;
					smp.target <= cur.tgt;
					smp.valid <= 1'b1;
					if (!calm && $urandom_range(3) == 0) gap = $urandom_range(1, 14);
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted on its own
	int hold_cnt, hold_seen;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_cnt <= 6000;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// result monitor and ready stalls
	int stall;
	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_outcomes.size() == 0) begin
					report("unexpected transfer, done_operation", res.done_operation, -1);
				end else begin
					e = expected_outcomes.pop_front();
					if (res.vote_total !== e.sum) report("vote_total", res.vote_total, e.sum);
					if (res.done_operation !== e.op)
						report("done_operation", res.done_operation, e.op);
				end
			end
			if (hold_cnt > 0) begin
				res.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				if (!calm && $urandom_range(4) == 0) stall = $urandom_range(1, 14);
			end
		end
	end

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || expected_outcomes.size() > 0 || smp.valid)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic setup(int unsigned t, int unsigned s, int unsigned nf, int unsigned nc,
			int unsigned sd);
		drain();
		reg_write(CFG_VOTE_THRESHOLD, t);
		reg_write(CFG_SPECIFICITY, s);
		reg_write(CFG_FEATURES, nf);
		reg_write(CFG_CLAUSES, nc);
		reg_write(CFG_SEED, sd);
		thr_reg = t;
		spec_reg = s;
		nfeat_reg = nf;
		nclause_reg = nc;
		seed_reg = sd;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic void queue_item(logic [OP_W-1:0] op, logic [31:0] w, bit last,
			bit hold);
		sample_t it;
		it.op = op;
		it.word = w;
		it.last = last;
		it.tgt = $urandom_range(1);
		it.hold = hold;
		pending_samples.push_back(it);
	endfunction

	function automatic void queue_sample(logic [OP_W-1:0] op, int len);
		bit hold;
		hold = $urandom_range(19) == 0;
		for (int i = 0; i < len; i++)
			queue_item(op, pick_word(), i == len - 1, hold && i == 0);
	endfunction

	// one setting: reseed or reinit, then a run of random samples
	task automatic run_setting(int nsamp, bit reseed);
		int len;
		@(negedge clk);
		queue_item(reseed ? OP_INIT : OP_REINIT, $urandom, $urandom_range(1), 1'b0);
		for (int i = 0; i < nsamp; i++) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
			if ($urandom_range(11) == 0)
				queue_item($urandom_range(1) ? OP_INIT : OP_REINIT, $urandom,
					$urandom_range(1), 1'b0);
			queue_sample($urandom_range(1) ? OP_UPDATE : OP_SCORE, len);
		end
	endtask

	// stimulus
	initial begin
		errors = 0;
		calm = 1'b0;
		hold_seq = 0;
		wpos = 0;
		thr_reg = 15;
		spec_reg = 4;
		nfeat_reg = 256;
		nclause_reg = 64;
		seed_reg = 0;
		rng0 = '0;
		rng1 = '0;
		for (int i = 0; i < 8; i++) words[i] = '0;
		@(posedge arst_n);

		// full size at reset values: fill every buffer slot before any short sample
		setup(15, 4, 256, 64, 0);
		@(negedge clk);
		queue_item(OP_INIT, 32'h0, 1'b0, 1'b0);
		for (int i = 0; i < 8; i++)
			queue_item(OP_SCORE, (i & 1) ? 32'hFFFF_FFFF : 32'h0, i == 7, 1'b0);
		for (int i = 0; i < 8; i++) queue_item(OP_UPDATE, $urandom, i == 7, 1'b0);
		// sender waits here until every earlier result has come back
		queue_item(OP_SCORE, 32'hFFFF_FFFF, 1'b1, 1'b1);

		// extremes of the settings
		setup(1, 0, 1, 1, 32'hFFFF_FFFF);
		run_setting(4, 1'b1);
		setup(1024, 65535, 33, 2, 1);
		run_setting(4, 1'b1);
		setup(2, 1, 40, 8, $urandom);
		run_setting(4, 1'b0);

		// random settings, mostly small sizes
		for (int p = 0; p < 8; p++) begin
			setup($urandom_range(1, 1024) >> $urandom_range(7), $urandom_range(0, 65535) >>
				$urandom_range(15), $urandom_range(1, 40), $urandom_range(1, 8), $urandom);
			if (p == 3) begin
				@(negedge clk);
				hold_seq++;
			end
			if (p == 7) calm = 1'b1;
			run_setting(4, $urandom_range(1));
		end

		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
+incdir+rtl
rtl/tmti_pkg.sv
rtl/tmti_ifs.sv
rtl/tmti_divider.sv
rtl/tmti_rng.sv
rtl/tmti_datapath.sv
rtl/tmti_ctrl.sv
rtl/tsetlin_machine_train_infer.sv
sim/tb_tsetlin_machine_train_infer.sv
